@@ src/usb_msc_bulk_only_sequencer_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the bulk-only sequencer
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef USB_MSC_BULK_ONLY_SEQUENCER_CORE_ASSERT_SVH
`define USB_MSC_BULK_ONLY_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check on every edge outside reset
`define MSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define MSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSC_ASSERT(label, clk, rst, prop, msg)
`define MSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/msc_bot_pkg.sv @@
// ---------------------------------------------------------------------------
// msc_bot_pkg
// Types, codes and helpers shared by the bulk-only transport sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package msc_bot_pkg;

  // event codes of an input transaction
  localparam logic [1:0] OP_CBW   = 2'd0;
  localparam logic [1:0] OP_OUT   = 2'd1;
  localparam logic [1:0] OP_IN    = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  // result kinds
  localparam logic [3:0] KIND_INQUIRY    = 4'd0;
  localparam logic [3:0] KIND_CAPACITIES = 4'd1;
  localparam logic [3:0] KIND_CAPACITY   = 4'd2;
  localparam logic [3:0] KIND_MODESENSE  = 4'd3;
  localparam logic [3:0] KIND_LOGSENSE   = 4'd4;
  localparam logic [3:0] KIND_CSW        = 4'd5;
  localparam logic [3:0] KIND_READSEC    = 4'd6;
  localparam logic [3:0] KIND_SENDPKT    = 4'd7;
  localparam logic [3:0] KIND_STOREPKT   = 4'd8;
  localparam logic [3:0] KIND_WRITESEC   = 4'd9;
  localparam logic [3:0] KIND_FAULT      = 4'd10;

  // SCSI opcodes
  localparam logic [7:0] OPC_INQUIRY    = 8'h12;
  localparam logic [7:0] OPC_FMT_CAPS   = 8'h23;
  localparam logic [7:0] OPC_MODESENSE  = 8'h1A;
  localparam logic [7:0] OPC_READ_CAP   = 8'h25;
  localparam logic [7:0] OPC_READ_CAP16 = 8'h9E;
  localparam logic [7:0] OPC_LOGSENSE   = 8'h4D;
  localparam logic [7:0] OPC_READ10     = 8'h28;
  localparam logic [7:0] OPC_WRITE10    = 8'h2A;

  localparam logic [31:0] CBW_SIG = 32'h4342_5355;
  localparam logic [6:0]  CBW_LEN = 7'd31;

  localparam logic [12:0] INQUIRY_LEN = 13'd36;
  localparam logic [12:0] SENSE_LEN   = 13'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TOTAL_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd1;

  localparam logic [12:0] BLOCK_BYTES_RESET = 13'd512;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  cbw_bytes;
    logic [31:0] signature;
    logic [31:0] cmd_tag;
    logic [31:0] xfer_bytes;
    logic [7:0]  opcode;
    logic [31:0] lba;
    logic [15:0] block_count;
    logic [6:0]  packet_bytes;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] csw_tag;
    logic [31:0] sector_addr;
    logic [15:0] sector_count;
    logic [12:0] buf_offset;
    logic [12:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic result_t mk_result(logic [3:0] kind, logic [31:0] tag,
                                        logic [31:0] addr, logic [15:0] cnt,
                                        logic [12:0] ofs, logic [12:0] len);
    result_t r;
    r.kind         = kind;
    r.csw_tag      = tag;
    r.sector_addr  = addr;
    r.sector_count = cnt;
    r.buf_offset   = ofs;
    r.length       = len;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/msc_bot_div.sv @@
// ---------------------------------------------------------------------------
// msc_bot_div
// Restoring divider: sectors that fit the buffer, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module msc_bot_div #(
  parameter int BUF_BYTES = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [12:0]                      divisor,
  output logic [$clog2(BUF_BYTES + 1) - 1:0]    quotient,
  output msc_bot_pkg::div_status_t              status
);

  localparam int QW    = $clog2(BUF_BYTES + 1);
  localparam int CNT_W = $clog2(QW);
  localparam logic [QW-1:0] DIVIDEND = QW'(BUF_BYTES);

  logic [CNT_W-1:0] cnt;
  logic [12:0]      rem;
  logic [12:0]      dsr;
  logic [QW-1:0]    q;
  logic             busy;
  logic             done;
  logic [13:0]      trial;
  logic             fits;

  assign trial = {rem, DIVIDEND[cnt]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW - 1);
        rem  <= '0;
        q    <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        // trial stays below the divisor when it does not fit
        rem <= fits ? 13'(trial - {1'b0, dsr}) : trial[12:0];
        q   <= {q[QW-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient    = q;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

@@ src/usb_msc_bulk_only_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// usb_msc_bulk_only_sequencer_core
// Control sequencer of a mass-storage bulk-only device.
// ---------------------------------------------------------------------------
// Input channel (item_valid/item_stall, payload item): one transaction per
// event - a parsed CBW, an OUT data packet length, an IN token or an
// interface reset. Output channel (result_valid/result_stall, payload
// result): zero to three commands per event, the final one flagged last.
// Configuration channel (cfg_valid/cfg_ready, always ready): register 0 is
// the disk block count, register 1 the block size; write only while idle.
// Each event runs a restoring divider for the sectors that fit the buffer,
// one quotient bit a cycle, then picks up the quotient and takes three
// steps for chunk, byte product and decode. The next event is taken the
// cycle after the last result enters the output register.
// While result_stall is high the output register holds and the sequencer
// waits; a new event is accepted while the last result is still waiting.
// Reset returns the phase to wait-CBW, clears the transfer state and
// restores the default register values; no event is taken during reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "usb_msc_bulk_only_sequencer_core_assert.svh"

module usb_msc_bulk_only_sequencer_core #(
  parameter int BUF_BYTES = 4096,
  parameter int EP_BYTES  = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire msc_bot_pkg::item_t    item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output msc_bot_pkg::result_t       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int QW = $clog2(BUF_BYTES + 1);
  localparam int CW = (QW > 16) ? QW : 16;
  localparam logic [31:0] BUF_LIMIT = 32'(BUF_BYTES);
  localparam logic [31:0] EP_LIMIT  = 32'(EP_BYTES);

  typedef enum logic [1:0] {PH_CBW, PH_CSW, PH_RECV, PH_SEND} phase_t;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CHUNK, S_PROD, S_EXEC, S_EMIT} fsm_t;

  fsm_t                 state;
  phase_t               phase;
  phase_t               phase_next;
  logic [31:0]          total_blocks;
  logic [12:0]          block_bytes;
  logic [31:0]          saved_tag;
  logic [31:0]          saved_tag_next;
  logic [31:0]          residue;
  logic [31:0]          residue_next;
  logic [31:0]          start_block;
  logic [31:0]          start_block_next;
  logic [15:0]          total_count;
  logic [15:0]          total_count_next;
  logic [15:0]          done_count;
  logic [15:0]          done_count_next;
  logic [12:0]          byte_offset;
  logic [12:0]          byte_offset_next;

  msc_bot_pkg::item_t   itm;
  logic [15:0]          chunk;
  logic [12:0]          chunk_bytes;
  msc_bot_pkg::result_t slot [3];
  msc_bot_pkg::result_t slot_next [3];
  logic [1:0]           n_slots;
  logic [1:0]           n_next;
  logic [1:0]           emit_idx;

  logic                        accept;
  logic [QW-1:0]               quot;
  msc_bot_pkg::div_status_t    div_status;
  logic                        fit_ok;
  logic [15:0]                 left;
  logic [CW-1:0]               fit_w;
  logic [25:0]                 mul;
  logic                        out_free;

  assign item_stall = rst || (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;

  msc_bot_div #(
    .BUF_BYTES (BUF_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .divisor  (block_bytes),
    .quotient (quot),
    .status   (div_status)
  );

  // chunk: sectors left for this transfer, capped by what fits the buffer
  assign fit_ok = (block_bytes != '0) && ({19'b0, block_bytes} <= BUF_LIMIT);
  assign left   = (itm.op == msc_bot_pkg::OP_CBW) ? itm.block_count
                                                  : 16'(total_count - done_count);
  assign fit_w  = fit_ok ? CW'(quot) : '0;
  assign mul    = chunk[12:0] * block_bytes;

  always_comb begin
    logic [31:0] res_v;
    logic [12:0] ofs_v;
    logic [15:0] done_v;
    logic [31:0] base_v;
    logic [1:0]  n_v;
    logic        rd_go;
    logic        rd_cbw;
    logic        wr_go;
    logic [12:0] len;
    logic [12:0] pkt;

    phase_next       = phase;
    saved_tag_next   = saved_tag;
    total_count_next = total_count;
    res_v            = residue;
    ofs_v            = byte_offset;
    done_v           = done_count;
    base_v           = start_block;
    n_v              = '0;
    rd_go            = 1'b0;
    rd_cbw           = 1'b0;
    wr_go            = 1'b0;
    len              = '0;
    pkt              = {6'b0, itm.packet_bytes};
    for (int i = 0; i < 3; i++) begin
      slot_next[i] = '0;
    end

    case (itm.op)
      msc_bot_pkg::OP_CBW: begin
        if (phase == PH_CBW) begin
          if (itm.cbw_bytes != msc_bot_pkg::CBW_LEN) begin
            slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_FAULT,
                                                    '0, '0, '0, '0, '0);
            n_v = n_v + 1'b1;
          end else if (itm.signature == msc_bot_pkg::CBW_SIG) begin
            saved_tag_next = itm.cmd_tag;
            res_v          = itm.xfer_bytes;
            case (itm.opcode)
              msc_bot_pkg::OPC_INQUIRY: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_INQUIRY,
                                   '0, '0, '0, '0, msc_bot_pkg::INQUIRY_LEN);
                n_v        = n_v + 1'b1;
                phase_next = PH_CSW;
              end
              msc_bot_pkg::OPC_FMT_CAPS: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_CAPACITIES,
                                   '0, total_blocks, '0, '0, block_bytes);
                n_v        = n_v + 1'b1;
                phase_next = PH_CSW;
              end
              msc_bot_pkg::OPC_MODESENSE: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_MODESENSE,
                                   '0, '0, '0, '0, msc_bot_pkg::SENSE_LEN);
                n_v        = n_v + 1'b1;
                phase_next = PH_CSW;
              end
              msc_bot_pkg::OPC_READ_CAP, msc_bot_pkg::OPC_READ_CAP16: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_CAPACITY,
                                   '0, total_blocks - 32'd1, '0, '0, block_bytes);
                n_v        = n_v + 1'b1;
                phase_next = PH_CSW;
              end
              msc_bot_pkg::OPC_LOGSENSE: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_LOGSENSE,
                                   '0, '0, '0, '0, msc_bot_pkg::SENSE_LEN);
                n_v        = n_v + 1'b1;
                phase_next = PH_CSW;
              end
              msc_bot_pkg::OPC_READ10, msc_bot_pkg::OPC_WRITE10: begin
                base_v           = itm.lba;
                total_count_next = itm.block_count;
                done_v           = '0;
                ofs_v            = '0;
                if (itm.opcode == msc_bot_pkg::OPC_WRITE10) begin
                  phase_next = PH_RECV;
                end else begin
                  rd_go  = 1'b1;
                  rd_cbw = 1'b1;
                end
              end
              default: begin
                slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_CSW,
                                   itm.cmd_tag, '0, '0, '0, '0);
                n_v        = n_v + 1'b1;
                phase_next = PH_CBW;
              end
            endcase
          end
        end
      end
      msc_bot_pkg::OP_OUT: begin
        wr_go = (phase == PH_RECV);
      end
      msc_bot_pkg::OP_IN: begin
        if (phase == PH_SEND) begin
          rd_go = 1'b1;
        end else if (phase == PH_CSW) begin
          slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_CSW,
                             saved_tag, '0, '0, '0, '0);
          n_v        = n_v + 1'b1;
          phase_next = PH_CBW;
        end
      end
      msc_bot_pkg::OP_RESET: begin
        phase_next = PH_CBW;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // IN side: load a new chunk at a chunk boundary, then send one packet
    if (rd_go) begin
      if (ofs_v == '0 || ofs_v == chunk_bytes) begin
        if (chunk != '0) begin
          slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_READSEC,
                             '0, base_v + {16'b0, done_v}, chunk, '0, '0);
          n_v = n_v + 1'b1;
        end
        done_v = done_v + chunk;
        ofs_v  = '0;
      end
      len = (res_v > EP_LIMIT) ? EP_LIMIT[12:0] : res_v[12:0];
      slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_SENDPKT,
                         '0, '0, '0, ofs_v, len);
      n_v   = n_v + 1'b1;
      ofs_v = ofs_v + len;
      res_v = res_v - {19'b0, len};
      if (rd_cbw) begin
        phase_next = (res_v == '0) ? PH_CSW : PH_SEND;
      end else if (res_v == '0) begin
        phase_next = PH_CSW;
      end
    end

    // OUT side: store the packet, flush a full chunk, close on empty residue
    if (wr_go) begin
      slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_STOREPKT,
                         '0, '0, '0, ofs_v, pkt);
      n_v   = n_v + 1'b1;
      res_v = (res_v > {19'b0, pkt}) ? res_v - {19'b0, pkt} : '0;
      ofs_v = ofs_v + pkt;
      if (ofs_v == chunk_bytes) begin
        if (chunk != '0) begin
          slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_WRITESEC,
                             '0, base_v + {16'b0, done_v}, chunk, '0, '0);
          n_v = n_v + 1'b1;
        end
        done_v = done_v + chunk;
        ofs_v  = '0;
      end
      if (res_v == '0) begin
        slot_next[n_v] = msc_bot_pkg::mk_result(msc_bot_pkg::KIND_CSW,
                           saved_tag, '0, '0, '0, '0);
        n_v        = n_v + 1'b1;
        phase_next = PH_CBW;
      end
    end

    if (n_v != '0) begin
      slot_next[n_v - 1'b1].last = 1'b1;
    end

    residue_next     = res_v;
    byte_offset_next = ofs_v;
    done_count_next  = done_v;
    start_block_next = base_v;
    n_next           = n_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_CBW;
      total_blocks <= '0;
      block_bytes  <= msc_bot_pkg::BLOCK_BYTES_RESET;
      saved_tag    <= '0;
      residue      <= '0;
      start_block  <= '0;
      total_count  <= '0;
      done_count   <= '0;
      byte_offset  <= '0;
      result_valid <= 1'b0;
      n_slots      <= '0;
      emit_idx     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msc_bot_pkg::CFG_TOTAL_BLOCKS: total_blocks <= cfg_data;
          msc_bot_pkg::CFG_BLOCK_BYTES:  block_bytes  <= cfg_data[12:0];
          default: begin
          end
        endcase
      end

      // load a new transaction, or drop the one just taken
      if (state == S_EMIT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            itm   <= item;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_CHUNK;
          end
        end
        S_CHUNK: begin
          chunk <= (CW'(left) > fit_w) ? fit_w[15:0] : left;
          state <= S_PROD;
        end
        S_PROD: begin
          chunk_bytes <= mul[12:0];
          state       <= S_EXEC;
        end
        S_EXEC: begin
          phase       <= phase_next;
          saved_tag   <= saved_tag_next;
          residue     <= residue_next;
          start_block <= start_block_next;
          total_count <= total_count_next;
          done_count  <= done_count_next;
          byte_offset <= byte_offset_next;
          for (int i = 0; i < 3; i++) begin
            slot[i] <= slot_next[i];
          end
          n_slots  <= n_next;
          emit_idx <= '0;
          state    <= (n_next == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          // hand results to the output register one transaction at a time
          if (out_free) begin
            result   <= slot[emit_idx];
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == n_slots - 1'b1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MSC_ASSERT_ALWAYS(a_no_accept_in_reset, clk, rst |-> item_stall, "event taken during reset")
  `MSC_ASSERT(a_accept_blocks, clk, rst, accept |=> item_stall, "input not blocked after accept")
  `MSC_ASSERT(a_div_done_in_div, clk, rst, div_status.done |-> state == S_DIV, "divider done out of step")
  `MSC_ASSERT(a_emit_in_range, clk, rst, state == S_EMIT |-> emit_idx < n_slots, "emit index overrun")

endmodule

`default_nettype wire

@@ tb/sv/tb_usb_msc_bulk_only_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// tb_usb_msc_bulk_only_sequencer_core
// Self-checking bench for the bulk-only transport sequencer. It sends CBWs,
// OUT packets, IN tokens and interface resets, predicts every command the
// core should issue and compares each result transaction field by field.
// ---------------------------------------------------------------------------
module tb_usb_msc_bulk_only_sequencer_core;
  import msc_bot_pkg::*;

  localparam int BUF_BYTES     = 4096;
  localparam int EP_BYTES      = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [1:0] CFG_NO_REG = 2'd3;

  typedef enum logic [1:0] {
    PH_WAIT_CBW,
    PH_SEND_CSW,
    PH_RECEIVING,
    PH_SENDING
  } bot_phase_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = CFG_TOTAL_BLOCKS;
  logic [31:0] cfg_data     = '0;

  int send_idle_pct = 20;
  int stall_pct     = 57;
  int cycle_count   = 0;
  bit bad_seen      = 1'b0;

  // sequencer state as predicted
  logic [31:0] disk_blocks   = '0;
  logic [12:0] blk_bytes     = BLOCK_BYTES_RESET;
  bot_phase_t  bot_phase     = PH_WAIT_CBW;
  logic [31:0] saved_tag     = '0;
  logic [31:0] bytes_left    = '0;
  logic [31:0] first_sector  = '0;
  logic [15:0] total_sectors = '0;
  logic [15:0] sectors_done  = '0;
  logic [12:0] buf_ofs       = '0;

  result_t step_cmds [0:2];
  int      step_count;
  result_t expected_cmds [$];
  result_t next_cmd;

  usb_msc_bulk_only_sequencer_core #(
    .BUF_BYTES(BUF_BYTES),
    .EP_BYTES (EP_BYTES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[usb_msc_bulk_only_sequencer_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---- prediction ----------------------------------------------------------

  function automatic void push_cmd(input logic [3:0] kind, input logic [31:0] tag,
                                   input logic [31:0] addr, input logic [15:0] cnt,
                                   input logic [12:0] ofs, input logic [12:0] len);
    result_t r;
    r.kind         = kind;
    r.csw_tag      = tag;
    r.sector_addr  = addr;
    r.sector_count = cnt;
    r.buf_offset   = ofs;
    r.length       = len;
    r.last         = 1'b0;
    step_cmds[step_count] = r;
    step_count++;
  endfunction

  // sectors of the next chunk: what is left, capped by what fits the buffer
  function automatic logic [15:0] chunk_blocks();
    logic [15:0] left;
    logic [15:0] fit;
    left = total_sectors - sectors_done;
    fit  = '0;
    if (blk_bytes != 0 && blk_bytes <= BUF_BYTES)
      fit = 16'(BUF_BYTES / blk_bytes);
    return (left > fit) ? fit : left;
  endfunction

  function automatic void predict_read_packet();
    logic [15:0] chunk;
    logic [31:0] prod;
    logic [31:0] len;
    chunk = chunk_blocks();
    prod  = chunk * blk_bytes;
    // refill the buffer at the start and once the chunk is drained
    if (buf_ofs == 0 || buf_ofs == prod[12:0]) begin
      if (chunk != 0)
        push_cmd(KIND_READSEC, '0, first_sector + sectors_done, chunk, '0, '0);
      sectors_done = sectors_done + chunk;
      buf_ofs      = '0;
    end
    len = (bytes_left > EP_BYTES) ? EP_BYTES : bytes_left;
    push_cmd(KIND_SENDPKT, '0, '0, '0, buf_ofs, len[12:0]);
    buf_ofs    = buf_ofs + len[12:0];
    bytes_left = bytes_left - len;
  endfunction

  function automatic void predict_commands(input item_t it);
    logic [15:0] chunk;
    logic [31:0] prod;
    step_count = 0;
    case (it.op)
      OP_CBW: begin
        if (bot_phase == PH_WAIT_CBW) begin
          if (it.cbw_bytes != CBW_LEN) begin
            push_cmd(KIND_FAULT, '0, '0, '0, '0, '0);
          end else if (it.signature == CBW_SIG) begin
            saved_tag  = it.cmd_tag;
            bytes_left = it.xfer_bytes;
            bot_phase  = PH_SEND_CSW;
            case (it.opcode)
              OPC_INQUIRY:   push_cmd(KIND_INQUIRY, '0, '0, '0, '0, INQUIRY_LEN);
              OPC_FMT_CAPS:  push_cmd(KIND_CAPACITIES, '0, disk_blocks, '0, '0, blk_bytes);
              OPC_MODESENSE: push_cmd(KIND_MODESENSE, '0, '0, '0, '0, SENSE_LEN);
              OPC_READ_CAP, OPC_READ_CAP16: begin
                push_cmd(KIND_CAPACITY, '0, disk_blocks - 32'd1, '0, '0, blk_bytes);
              end
              OPC_LOGSENSE:  push_cmd(KIND_LOGSENSE, '0, '0, '0, '0, SENSE_LEN);
              OPC_READ10, OPC_WRITE10: begin
                first_sector  = it.lba;
                total_sectors = it.block_count;
                sectors_done  = '0;
                buf_ofs       = '0;
                if (it.opcode == OPC_WRITE10) begin
                  bot_phase = PH_RECEIVING;
                end else begin
                  predict_read_packet();
                  bot_phase = (bytes_left == 0) ? PH_SEND_CSW : PH_SENDING;
                end
              end
              default: begin
                push_cmd(KIND_CSW, saved_tag, '0, '0, '0, '0);
                bot_phase = PH_WAIT_CBW;
              end
            endcase
          end
        end
      end
      OP_OUT: begin
        if (bot_phase == PH_RECEIVING) begin
          chunk = chunk_blocks();
          push_cmd(KIND_STOREPKT, '0, '0, '0, buf_ofs, {6'd0, it.packet_bytes});
          bytes_left = (bytes_left > it.packet_bytes) ? bytes_left - it.packet_bytes : '0;
          buf_ofs    = buf_ofs + it.packet_bytes;
          prod       = chunk * blk_bytes;
          // flush the buffer once the chunk is full
          if (buf_ofs == prod[12:0]) begin
            if (chunk != 0)
              push_cmd(KIND_WRITESEC, '0, first_sector + sectors_done, chunk, '0, '0);
            sectors_done = sectors_done + chunk;
            buf_ofs      = '0;
          end
          if (bytes_left == 0) begin
            push_cmd(KIND_CSW, saved_tag, '0, '0, '0, '0);
            bot_phase = PH_WAIT_CBW;
          end
        end
      end
      OP_IN: begin
        if (bot_phase == PH_SENDING) begin
          predict_read_packet();
          if (bytes_left == 0)
            bot_phase = PH_SEND_CSW;
        end else if (bot_phase == PH_SEND_CSW) begin
          push_cmd(KIND_CSW, saved_tag, '0, '0, '0, '0);
          bot_phase = PH_WAIT_CBW;
        end
      end
      default: bot_phase = PH_WAIT_CBW;
    endcase
    if (step_count > 0)
      step_cmds[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++)
      expected_cmds.push_back(step_cmds[i]);
  endfunction

  // ---- checking ------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      bad_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_cmds.size() == 0) begin
        $error("kind: expected no transaction, got 0x%0h", result.kind);
        bad_seen = 1'b1;
      end else begin
        next_cmd = expected_cmds.pop_front();
        check_field("kind", next_cmd.kind, result.kind);
        check_field("csw_tag", next_cmd.csw_tag, result.csw_tag);
        check_field("sector_addr", next_cmd.sector_addr, result.sector_addr);
        check_field("sector_count", next_cmd.sector_count, result.sector_count);
        check_field("buf_offset", next_cmd.buf_offset, result.buf_offset);
        check_field("length", next_cmd.length, result.length);
        check_field("last", next_cmd.last, result.last);
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------

  // hold valid and payload until the transaction is taken
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    predict_commands(it);
  endtask

  // drop valid, drain all expected results, then let a silent event finish
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOTAL_BLOCKS: disk_blocks = data;
      CFG_BLOCK_BYTES:  blk_bytes   = data[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic item_t make_cbw(input logic [7:0] opc, input logic [31:0] tag,
                                     input logic [31:0] xfer, input logic [31:0] lba,
                                     input logic [15:0] count);
    item_t it;
    it.op           = OP_CBW;
    it.cbw_bytes    = CBW_LEN;
    it.signature    = CBW_SIG;
    it.cmd_tag      = tag;
    it.xfer_bytes   = xfer;
    it.opcode       = opc;
    it.lba          = lba;
    it.block_count  = count;
    it.packet_bytes = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic item_t make_token(input logic [1:0] op, input logic [6:0] pkt);
    item_t it;
    it              = make_cbw(8'($urandom()), $urandom(), $urandom(), $urandom(),
                               16'($urandom()));
    it.op           = op;
    it.cbw_bytes    = 7'($urandom_range(0, 127));
    it.packet_bytes = pkt;
    return it;
  endfunction

  function automatic logic [7:0] random_opcode();
    case ($urandom_range(0, 8))
      0: return OPC_INQUIRY;
      1: return OPC_FMT_CAPS;
      2: return OPC_MODESENSE;
      3: return OPC_READ_CAP;
      4: return OPC_READ_CAP16;
      5: return OPC_LOGSENSE;
      6: return OPC_READ10;
      7: return OPC_WRITE10;
      default: return 8'($urandom());
    endcase
  endfunction

  // mostly the event the current phase wants, with some noise mixed in
  function automatic item_t random_event();
    item_t it;
    int    pick;
    it = make_cbw(random_opcode(), $urandom(),
                  ($urandom_range(99) < 6) ? $urandom() : $urandom_range(0, 600),
                  $urandom(),
                  16'(($urandom_range(99) < 6) ? $urandom() : $urandom_range(0, 24)));
    pick = $urandom_range(99);
    if (pick < 12) begin
      it.op           = 2'($urandom_range(0, 3));
      it.packet_bytes = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 1))
        it.cbw_bytes = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 1))
        it.signature = $urandom();
    end else begin
      case (bot_phase)
        PH_WAIT_CBW: ;
        PH_RECEIVING: begin
          it.op           = OP_OUT;
          it.packet_bytes = 7'((pick < 70) ? EP_BYTES : $urandom_range(0, EP_BYTES));
        end
        default: it.op = OP_IN;
      endcase
    end
    return it;
  endfunction

  // ---- tests ---------------------------------------------------------------

  task automatic test_reply_commands();
    send_item(make_cbw(OPC_INQUIRY, 32'h0, 32'd36, $urandom(), 16'($urandom())));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(OPC_FMT_CAPS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(),
                       16'($urandom())));
    // OUT packet in the CSW phase is dropped
    send_item(make_token(OP_OUT, 7'd64));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(OPC_READ_CAP, $urandom(), 32'd8, $urandom(), 16'($urandom())));
    send_item(make_token(OP_RESET, 7'd0));
    send_item(make_cbw(OPC_READ_CAP16, $urandom(), 32'd32, $urandom(), 16'($urandom())));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(OPC_MODESENSE, $urandom(), 32'd4, $urandom(), 16'($urandom())));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(OPC_LOGSENSE, $urandom(), 32'd4, $urandom(), 16'($urandom())));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(8'hFF, $urandom(), 32'd0, $urandom(), 16'($urandom())));
  endtask

  task automatic test_cbw_faults();
    item_t it;
    it = make_cbw(OPC_INQUIRY, $urandom(), 32'd36, $urandom(), 16'($urandom()));
    it.cbw_bytes = 7'd0;
    send_item(it);
    it.cbw_bytes = 7'h7F;
    send_item(it);
    it.cbw_bytes = CBW_LEN;
    it.signature = ~CBW_SIG;
    send_item(it);
    // IN token while waiting for a CBW is dropped
    send_item(make_token(OP_IN, 7'd0));
  endtask

  task automatic test_read10();
    send_item(make_cbw(OPC_READ10, $urandom(), 32'd0, 32'h0, 16'd1));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_cbw(OPC_READ10, $urandom(), 32'd100, 32'hFFFF_FFFF, 16'd1));
    send_item(make_token(OP_IN, 7'd0));
    send_item(make_token(OP_IN, 7'd0));
  endtask

  task automatic test_write10();
    wait_idle();
    write_reg(CFG_BLOCK_BYTES, 32'd32);
    send_item(make_cbw(OPC_WRITE10, $urandom(), 32'd128, $urandom(), 16'd2));
    send_item(make_token(OP_OUT, 7'd64));
    send_item(make_token(OP_OUT, 7'd64));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int n,
                                     input logic [31:0] blocks, input logic [12:0] bsize);
    logic [31:0] size_word;
    wait_idle();
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    size_word        = $urandom();
    size_word[12:0]  = bsize;
    write_reg(CFG_TOTAL_BLOCKS, blocks);
    write_reg(CFG_BLOCK_BYTES, size_word);
    write_reg(CFG_NO_REG, $urandom());
    repeat (n) send_item(random_event());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reply_commands();
    test_cbw_faults();
    test_read10();
    test_write10();
    test_random_traffic(20, 57, 15, $urandom(), BLOCK_BYTES_RESET);
    test_random_traffic(20, 57, 15, 32'hFFFF_FFFF, 13'd1);
    test_random_traffic(57, 20, 12, $urandom(), 13'd4096);
    test_random_traffic(57, 20, 12, $urandom(), 13'd0);
    test_random_traffic(0, 0, 10, 32'h0, 13'h1FFF);
    test_random_traffic(0, 0, 10, $urandom(), 13'($urandom_range(8, 96)));
    wait_idle();
    if (!bad_seen && expected_cmds.size() == 0)
      $display("[usb_msc_bulk_only_sequencer_core] OK");
    else
      $display("[usb_msc_bulk_only_sequencer_core] ERROR");
    $finish;
  end

endmodule
